// ===== design/bmhq_pkg.sv =====
// Shared types, constants and conversion functions for the binary max-heap queue.
`timescale 1ns / 1ps

package bmhq_pkg;

	// Sizing of the heap.
	localparam int DEPTH    = 1024;
	localparam int KEY_BITS = 16;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);

	// Fixed widths of the port fields.
	localparam int FIELD_W     = 16;
	localparam int COUNT_OUT_W = 11;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	// Command codes of an input word.
	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_EXTRACT = 1'b1;

	// Status codes of a result word.
	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_EXTRACTED = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// One heap entry as it is held in memory.
	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [FIELD_W-1:0]  payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Memory access request from the sequencer.
	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		entry_t             wdata;
		logic               re;
		logic [ADDR_W-1:0]  raddr;
	} mem_req_t;

	// Finished result handed to the output register.
	typedef struct packed {
		status_t                 status;
		logic [FIELD_W-1:0]      key;
		logic [FIELD_W-1:0]      payload;
		logic [COUNT_OUT_W-1:0]  count;
	} result_t;

	// Keep the low KEY_BITS bits of a port key.
	function automatic logic [KEY_BITS-1:0] key_in(input logic [FIELD_W-1:0] k);
		logic [31:0] w;
		w = 32'(k);
		return w[KEY_BITS-1:0];
	endfunction

	// Widen or trim a stored key to the port width.
	function automatic logic [FIELD_W-1:0] key_out(input logic [KEY_BITS-1:0] k);
		logic [31:0] w;
		w = 32'(k);
		return w[FIELD_W-1:0];
	endfunction

	// Count masked to the port width.
	function automatic logic [COUNT_OUT_W-1:0] count_out(input logic [CNT_W-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[COUNT_OUT_W-1:0];
	endfunction

endpackage

// ===== design/bmhq_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/bmhq_ctrl.sv =====
// Sequencer that performs insert and extract with sift-up and sift-down over the heap memory.
`timescale 1ns / 1ps

module bmhq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          command,
	input  logic [bmhq_pkg::FIELD_W-1:0]  item_key,
	input  logic [bmhq_pkg::FIELD_W-1:0]  item_payload,
	output logic                          idle,
	output logic                          res_valid,
	input  logic                          res_take,
	output bmhq_pkg::result_t             res,
	output bmhq_pkg::mem_req_t            mem_req,
	input  bmhq_pkg::entry_t              mem_rdata
);

	import bmhq_pkg::*;

	localparam int CW = ADDR_W + 2;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_UP_CMP  = 9'b000000010,
		S_EX_ROOT = 9'b000000100,
		S_EX_LAST = 9'b000001000,
		S_DN_LEFT = 9'b000010000,
		S_DN_CMP  = 9'b000100000,
		S_WR_HOLE = 9'b001000000,
		S_DONE    = 9'b010000000,
		S_SPARE   = 9'b100000000
	} state_t;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [ADDR_W-1:0]   pos_q, pos_d;
	entry_t              ent_q, ent_d;
	entry_t              left_q, left_d;
	logic                rv_q, rv_d;
	status_t             rstat_q, rstat_d;
	logic [KEY_BITS-1:0] rkey_q, rkey_d;
	logic [FIELD_W-1:0]  rpay_q, rpay_d;

	logic [CNT_W-1:0]    cnt_dec;
	logic [CW-1:0]       cnt_w;
	logic [CW-1:0]       lc, rc, child, nlc;
	logic [ADDR_W-1:0]   par, par_of_cnt, par_of_par;
	logic                take_l, take_r;
	logic [KEY_BITS-1:0] best_key;
	entry_t              child_ent;
	entry_t              new_ent;

	// Index arithmetic for the current hole position.
	always_comb begin
		cnt_dec    = cnt_q - CNT_W'(1);
		cnt_w      = CW'(cnt_q);
		lc         = CW'({pos_q, 1'b1});
		rc         = CW'({pos_q, 1'b0}) + CW'(2);
		par        = (pos_q - ADDR_W'(1)) >> 1;
		par_of_par = (par - ADDR_W'(1)) >> 1;
		par_of_cnt = (cnt_q[ADDR_W-1:0] - ADDR_W'(1)) >> 1;
		new_ent    = '{key: key_in(item_key), payload: item_payload};
	end

	// Child selection for one sift-down level; the left child wins a tie.
	always_comb begin
		take_l    = left_q.key > ent_q.key;
		best_key  = take_l ? left_q.key : ent_q.key;
		take_r    = rv_q && (mem_rdata.key > best_key);
		child     = take_r ? rc : lc;
		child_ent = take_r ? mem_rdata : left_q;
		nlc       = {child[CW-2:0], 1'b1};
	end

	// Next-state and memory request logic.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		ent_d   = ent_q;
		left_d  = left_q;
		rv_d    = rv_q;
		rstat_d = rstat_q;
		rkey_d  = rkey_q;
		rpay_d  = rpay_q;
		mem_req = '{we: 1'b0, waddr: pos_q, wdata: ent_q, re: 1'b0, raddr: '0};

		case (state_q)
			S_IDLE: begin
				if (start) begin
					rkey_d = '0;
					rpay_d = '0;
					if (command == CMD_INSERT) begin
						if (cnt_q == FULL_CNT) begin
							rstat_d = ST_FULL;
							state_d = S_DONE;
						end else begin
							rstat_d = ST_INSERTED;
							ent_d   = new_ent;
							cnt_d   = cnt_q + CNT_W'(1);
							pos_d   = cnt_q[ADDR_W-1:0];
							if (cnt_q == '0) begin
								mem_req.we    = 1'b1;
								mem_req.waddr = '0;
								mem_req.wdata = new_ent;
								state_d       = S_DONE;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = par_of_cnt;
								state_d       = S_UP_CMP;
							end
						end
					end else begin
						if (cnt_q == '0) begin
							rstat_d = ST_EMPTY;
							state_d = S_DONE;
						end else begin
							rstat_d       = ST_EXTRACTED;
							mem_req.re    = 1'b1;
							mem_req.raddr = '0;
							state_d       = S_EX_ROOT;
						end
					end
				end
			end

			// Parent data is back: move it down or drop the new entry here.
			S_UP_CMP: begin
				mem_req.we = 1'b1;
				if (ent_q.key > mem_rdata.key) begin
					mem_req.wdata = mem_rdata;
					pos_d         = par;
					if (par == '0) begin
						state_d = S_WR_HOLE;
					end else begin
						mem_req.re    = 1'b1;
						mem_req.raddr = par_of_par;
					end
				end else begin
					state_d = S_DONE;
				end
			end

			// Root is back: keep it as the result and fetch the last entry.
			S_EX_ROOT: begin
				rkey_d        = mem_rdata.key;
				rpay_d        = mem_rdata.payload;
				cnt_d         = cnt_dec;
				mem_req.re    = 1'b1;
				mem_req.raddr = cnt_dec[ADDR_W-1:0];
				state_d       = S_EX_LAST;
			end

			// Last entry is back: it becomes the hole entry at the root.
			S_EX_LAST: begin
				ent_d = mem_rdata;
				pos_d = '0;
				if (cnt_q == '0) begin
					state_d = S_DONE;
				end else if (cnt_w > CW'(1)) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = ADDR_W'(1);
					state_d       = S_DN_LEFT;
				end else begin
					state_d = S_WR_HOLE;
				end
			end

			// Left child is back: fetch the right child if it exists.
			S_DN_LEFT: begin
				left_d = mem_rdata;
				rv_d   = rc < cnt_w;
				if (rc < cnt_w) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rc[ADDR_W-1:0];
				end
				state_d = S_DN_CMP;
			end

			// Both children known: move the larger one up or settle the hole.
			S_DN_CMP: begin
				mem_req.we = 1'b1;
				if (take_l || take_r) begin
					mem_req.wdata = child_ent;
					pos_d         = child[ADDR_W-1:0];
					if (nlc < cnt_w) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = nlc[ADDR_W-1:0];
						state_d       = S_DN_LEFT;
					end else begin
						state_d = S_WR_HOLE;
					end
				end else begin
					state_d = S_DONE;
				end
			end

			S_WR_HOLE: begin
				mem_req.we = 1'b1;
				state_d    = S_DONE;
			end

			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		ent_q   <= ent_d;
		left_q  <= left_d;
		rv_q    <= rv_d;
		rstat_q <= rstat_d;
		rkey_q  <= rkey_d;
		rpay_q  <= rpay_d;
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = '{status:  rstat_q,
	                     key:     key_out(rkey_q),
	                     payload: rpay_q,
	                     count:   count_out(cnt_q)};

endmodule

// ===== design/binary_max_heap_queue.sv =====
// Top level of the binary max-heap queue: handshake, result register and heap memory.
//
//  Channel   Direction  Handshake            Word
//  in        input      in_valid / in_ready  command, item_key, item_payload
//  out       output     out_valid/out_ready  status, out_key, out_payload, entry_count
//
// A sequencer works one word at a time over one heap memory with a registered read.
// An insert into an empty heap writes the root directly; otherwise it climbs level by
// level. An extract reads the root and the last entry, then descends level by level;
// a full insert or an empty extract goes straight to the done state.
// Reset clears the entry count and the control state; the memory is not cleared.
// A new word is taken while the previous result waits; a stalled output holds the
// sequencer in its done state.
`timescale 1ns / 1ps

module binary_max_heap_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [bmhq_pkg::FIELD_W-1:0]  item_key,
	input  logic [bmhq_pkg::FIELD_W-1:0]  item_payload,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status,
	output logic [bmhq_pkg::FIELD_W-1:0]  out_key,
	output logic [bmhq_pkg::FIELD_W-1:0]  out_payload,
	output logic [bmhq_pkg::COUNT_OUT_W-1:0] entry_count
);

	import bmhq_pkg::*;

	logic                idle;
	logic                res_valid;
	logic                res_take;
	result_t             res;
	mem_req_t            mem_req;
	logic [ENTRY_W-1:0]  rdata;
	logic                out_valid_q;
	result_t             out_q;

	// Heap memory.
	bmhq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	// Sequencer.
	bmhq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_valid && in_ready),
		.command      (command),
		.item_key     (item_key),
		.item_payload (item_payload),
		.idle         (idle),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res),
		.mem_req      (mem_req),
		.mem_rdata    (entry_t'(rdata))
	);

	assign in_ready = idle;

	// The result register loads when empty or being drained.
	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign out_key     = out_q.key;
	assign out_payload = out_q.payload;
	assign entry_count = out_q.count;

endmodule

// ===== tb/tb_binary_max_heap_queue.sv =====
// Self-checking testbench for the binary max-heap queue with a shadow heap predictor.
`timescale 1ns / 1ps

module tb_binary_max_heap_queue;
	import bmhq_pkg::*;

	// Sender idle and receiver stall percentages per idling mode:
	// mode 0 none, mode 1 sender idle, mode 2 receiver stalls, mode 3 both.
	localparam logic [3:0][6:0] SEND_IDLE  = {7'd29, 7'd0, 7'd65, 7'd0};
	localparam logic [3:0][6:0] RECV_STALL = {7'd29, 7'd65, 7'd0, 7'd0};
	localparam int MODE_LEN = 150;
	localparam int TAIL_CYCLES = 64;

	// One input word waiting to be driven.
	typedef struct {
		logic               cmd;
		logic [FIELD_W-1:0] key;
		logic [FIELD_W-1:0] payload;
		int unsigned        mode;
		bit                 drain_first;
	} in_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   command = CMD_INSERT;
	logic [FIELD_W-1:0]     item_key = '0;
	logic [FIELD_W-1:0]     item_payload = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [1:0]             status;
	logic [FIELD_W-1:0]     out_key;
	logic [FIELD_W-1:0]     out_payload;
	logic [COUNT_OUT_W-1:0] entry_count;

	in_word_t    word_queue[$];
	result_t     expected_results[$];
	entry_t      shadow_heap[DEPTH];
	int          shadow_count = 0;
	int unsigned rx_mode = 0;
	int          fail_count = 0;

	binary_max_heap_queue i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.item_key     (item_key),
		.item_payload (item_payload),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_key      (out_key),
		.out_payload  (out_payload),
		.entry_count  (entry_count)
	);

	always #6 clk = ~clk;

	// Applies one word to the shadow heap and returns the result it must produce.
	function automatic result_t heap_apply(input logic cmd, input logic [FIELD_W-1:0] k,
			input logic [FIELD_W-1:0] p);
		result_t r;
		entry_t  tmp;
		int      pos;
		int      parent;
		int      best;
		int      lc;
		int      rc;
		bit      done;
		r.status  = ST_INSERTED;
		r.key     = '0;
		r.payload = '0;
		if (cmd == CMD_INSERT) begin
			if (shadow_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				shadow_heap[shadow_count].key     = k[KEY_BITS-1:0];
				shadow_heap[shadow_count].payload = p;
				pos = shadow_count;
				shadow_count++;
				// Climb while strictly greater than the parent.
				done = 1'b0;
				while (pos > 0 && !done) begin
					parent = (pos - 1) / 2;
					if (shadow_heap[pos].key > shadow_heap[parent].key) begin
						tmp = shadow_heap[pos];
						shadow_heap[pos] = shadow_heap[parent];
						shadow_heap[parent] = tmp;
						pos = parent;
					end else begin
						done = 1'b1;
					end
				end
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.status  = ST_EXTRACTED;
				r.key     = FIELD_W'(shadow_heap[0].key);
				r.payload = shadow_heap[0].payload;
				shadow_count--;
				shadow_heap[0] = shadow_heap[shadow_count];
				// Sink the moved entry; the left child wins a tie between children.
				pos = 0;
				done = (shadow_count == 0);
				while (!done) begin
					best = pos;
					lc = 2 * pos + 1;
					rc = 2 * pos + 2;
					if (lc < shadow_count && shadow_heap[lc].key > shadow_heap[best].key)
						best = lc;
					if (rc < shadow_count && shadow_heap[rc].key > shadow_heap[best].key)
						best = rc;
					if (best == pos) begin
						done = 1'b1;
					end else begin
						tmp = shadow_heap[pos];
						shadow_heap[pos] = shadow_heap[best];
						shadow_heap[best] = tmp;
						pos = best;
					end
				end
			end
		end
		r.count = COUNT_OUT_W'(shadow_count);
		return r;
	endfunction

	// Reports one field that differs from its expected value.
	function automatic void check_field(input string name, input logic [FIELD_W-1:0] want,
			input logic [FIELD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Driver: presents queued words and predicts each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(),
					heap_apply(command, item_key, item_payload));
			if (!in_valid || in_ready) begin
				if (word_queue.size() != 0
						&& !(word_queue[0].drain_first && expected_results.size() != 0)
						&& $urandom_range(0, 99) >= SEND_IDLE[word_queue[0].mode]) begin
					in_valid     <= 1'b1;
					command      <= word_queue[0].cmd;
					item_key     <= word_queue[0].key;
					item_payload <= word_queue[0].payload;
					rx_mode      <= word_queue[0].mode;
					void'(word_queue.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result word, status %0d key %0h payload %0h",
						$time, status, out_key, out_payload);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", FIELD_W'(want.status), FIELD_W'(status));
					check_field("out_key", want.key, out_key);
					check_field("out_payload", want.payload, out_payload);
					check_field("entry_count", FIELD_W'(want.count), FIELD_W'(entry_count));
				end
			end
			out_ready <= ($urandom_range(0, 99) >= RECV_STALL[rx_mode]);
		end
	end

	// Queues one input word.
	task automatic add_word(input logic cmd, input logic [FIELD_W-1:0] k,
			input logic [FIELD_W-1:0] p, input int unsigned mode, input bit drain_first);
		in_word_t w;
		w.cmd = cmd;
		w.key = k;
		w.payload = p;
		w.mode = mode;
		w.drain_first = drain_first;
		word_queue.insert(word_queue.size(), w);
	endtask

	// Random key, often drawn from a few values so that equal keys meet in the heap.
	function automatic logic [FIELD_W-1:0] pick_key();
		logic [FIELD_W-1:0] k;
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 3))
				0:       k = 16'h0000;
				1:       k = 16'hFFFF;
				2:       k = 16'h0100;
				default: k = 16'h0180;
			endcase
		end else begin
			k = FIELD_W'($urandom);
		end
		return k;
	endfunction

	// Stimulus, reset and end of run.
	initial begin
		int  gen_count;
		int  n;
		logic cmd;

		// Directed words: empty extract, key extremes, equal keys, then drain to empty.
		add_word(CMD_EXTRACT, 16'hFFFF, 16'hFFFF, 0, 1'b0);
		add_word(CMD_INSERT, 16'hFFFF, 16'hFFFF, 0, 1'b0);
		add_word(CMD_INSERT, 16'h0000, 16'h0000, 0, 1'b0);
		add_word(CMD_INSERT, 16'h0100, 16'hA5A5, 0, 1'b0);
		add_word(CMD_INSERT, 16'h0100, 16'h5A5A, 0, 1'b0);
		add_word(CMD_INSERT, 16'h0100, 16'h1234, 0, 1'b0);
		add_word(CMD_INSERT, 16'h8000, 16'h0001, 0, 1'b0);
		add_word(CMD_INSERT, 16'h0001, 16'h8000, 0, 1'b0);
		add_word(CMD_INSERT, 16'h0100, 16'h4321, 0, 1'b0);
		repeat (8)
			add_word(CMD_EXTRACT, FIELD_W'($urandom), FIELD_W'($urandom), 0, 1'b0);
		add_word(CMD_EXTRACT, 16'h0000, 16'h0000, 0, 1'b0);

		// Mostly inserts until the heap is full, with occasional extracts mixed in.
		gen_count = 0;
		n = 0;
		while (gen_count < DEPTH) begin
			cmd = ($urandom_range(0, 99) < 99) ? CMD_INSERT : CMD_EXTRACT;
			add_word(cmd, pick_key(), FIELD_W'($urandom), (n / MODE_LEN) % 4, n == 0);
			if (cmd == CMD_INSERT)
				gen_count++;
			else if (gen_count > 0)
				gen_count--;
			n++;
		end

		// Inserts against the full heap, one slot freed and refilled, then churn.
		add_word(CMD_INSERT, pick_key(), FIELD_W'($urandom), 0, 1'b1);
		repeat (3)
			add_word(CMD_INSERT, pick_key(), FIELD_W'($urandom), 3, 1'b0);
		add_word(CMD_EXTRACT, FIELD_W'($urandom), FIELD_W'($urandom), 3, 1'b0);
		add_word(CMD_INSERT, pick_key(), FIELD_W'($urandom), 2, 1'b0);
		add_word(CMD_INSERT, pick_key(), FIELD_W'($urandom), 1, 1'b0);
		for (int i = 0; i < 20; i++)
			add_word($urandom_range(0, 1) ? CMD_EXTRACT : CMD_INSERT, pick_key(),
				FIELD_W'($urandom), (i / 5) % 4, 1'b0);

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (word_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#6_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bmhq_pkg.sv
design/bmhq_ram.sv
design/bmhq_ctrl.sv
design/binary_max_heap_queue.sv
tb/tb_binary_max_heap_queue.sv
